### rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types for the character deque with purge
// Operation codes, sequencer states, and the packed beat types of the input
// and result channels.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Default number of characters the deque holds.
  localparam int CDQ_CAPACITY = 256;

  // Fixed field widths of the channels.
  localparam int OP_W     = 3;
  localparam int SYMBOL_W = 8;
  localparam int AMOUNT_W = 9;

  // Operation codes carried in an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PURGE      = 3'd4,
    OP_LENGTH     = 3'd5
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_PURGE
  } state_t;

  // One input beat.
  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SYMBOL_W-1:0] symbol;
  } cdq_in_t;

  // One result beat.
  typedef struct packed {
    logic [AMOUNT_W-1:0] amount;
    logic [SYMBOL_W-1:0] removed_symbol;
    logic                symbol_valid;
  } cdq_out_t;

endpackage

### rtl/char_deque_with_purge.sv
// ----------------------------------------------------------------------------
// char_deque_with_purge: bounded deque of 8-bit characters
// Ring store with a front slot and an element count. Pushes and pops at
// either end, a length query, and a purge that walks the stored elements
// and compacts away every copy of one character.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                 Handshake
//   --------  --------------------  -----------------------------------------
//   input     start, busy, in_item  beat taken at a rising edge with start
//                                   high and busy low
//   result    out_strobe, out_item  beat shown for one cycle, taken at the
//                                   edge that ends it
//
// Push, length, pop or purge of an empty deque and unknown codes leave busy
// low; length and the empty pop or purge show a result in the cycle after the
// beat is taken, while push and unknown codes give none. A pop reads the ring
// store once and raises busy for the ST_POP state, which registers its result.
// A purge raises busy for its walk: one read and at most one write of the ring
// store per cycle, pipelined over the stored elements.
// Reset clears the front slot, the count and the sequencer; the ring store
// is not cleared. The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
module char_deque_with_purge #(
  parameter int CAPACITY = cdq_pkg::CDQ_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cdq_pkg::cdq_in_t  in_item,
  output logic              out_strobe,
  output cdq_pkg::cdq_out_t out_item
);
  import cdq_pkg::*;

  // Slot index and count widths follow the capacity.
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [CW-1:0] CAP_M1_C  = CW'(CAPACITY - 1);
  localparam logic [CW:0]   CAP_W     = (CW + 1)'(CAPACITY);
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] ONE_C     = CW'(1);

  // Zero-extends or truncates a count into the amount field.
  function automatic logic [AMOUNT_W-1:0] to_amount(input logic [CW-1:0] v);
    logic [CW+AMOUNT_W-1:0] e;
    begin
      e = {{AMOUNT_W{1'b0}}, v};
      return e[AMOUNT_W-1:0];
    end
  endfunction

  // Steps a ring pointer by one slot with wraparound.
  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    begin
      return (p == LAST_SLOT) ? '0 : p + IW'(1);
    end
  endfunction

  // Architectural state.
  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  state_t        state_r, state_nxt;

  // Purge walk registers.
  logic [IW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [IW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]       left_r, left_nxt;
  logic [CW-1:0]       kept_r, kept_nxt;
  logic                pend_r, pend_nxt;
  logic [SYMBOL_W-1:0] sym_r, sym_nxt;

  // Result register.
  logic     out_strobe_r, out_strobe_nxt;
  cdq_out_t out_item_r, out_item_nxt;

  // Ring store ports.
  logic [SYMBOL_W-1:0] ring_mem [CAPACITY];
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [SYMBOL_W-1:0] mem_wdata;
  logic [SYMBOL_W-1:0] rd_data_r;

  // Shared slot unit: front plus an offset, reduced modulo the capacity.
  logic [CW-1:0] slot_off;
  logic [CW:0]   slot_sum;
  logic [CW:0]   slot_mod;
  logic [IW-1:0] slot_idx;

  logic accept;
  op_t  in_op;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign in_op  = op_t'(in_item.operation);

  // Offset fed to the slot unit for the operation being taken.
  always_comb begin
    case (in_op)
      OP_PUSH_FRONT: slot_off = CAP_M1_C;
      OP_PUSH_BACK:  slot_off = count_r;
      OP_POP_FRONT:  slot_off = ONE_C;
      OP_POP_BACK:   slot_off = count_r - ONE_C;
      default:       slot_off = '0;
    endcase
  end

  assign slot_sum = (CW + 1)'(front_r) + (CW + 1)'(slot_off);
  assign slot_mod = (slot_sum >= CAP_W) ? slot_sum - CAP_W : slot_sum;
  assign slot_idx = slot_mod[IW-1:0];

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && count_r != '0) begin
          if (in_op == OP_POP_FRONT || in_op == OP_POP_BACK) begin
            state_nxt = ST_POP;
          end else if (in_op == OP_PURGE) begin
            state_nxt = ST_PURGE;
          end
        end
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      ST_PURGE: begin
        if (left_r == '0 && !pend_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, ring store controls and result.
  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    left_nxt       = left_r;
    kept_nxt       = kept_r;
    pend_nxt       = 1'b0;
    sym_nxt        = sym_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_waddr      = slot_idx;
    mem_wdata      = in_item.symbol;
    mem_re         = 1'b0;
    mem_raddr      = slot_idx;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_PUSH_FRONT: begin
              if (count_r < CAP_C) begin
                mem_we    = 1'b1;
                front_nxt = slot_idx;
                count_nxt = count_r + ONE_C;
              end
            end
            OP_PUSH_BACK: begin
              if (count_r < CAP_C) begin
                mem_we    = 1'b1;
                count_nxt = count_r + ONE_C;
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                out_strobe_nxt = 1'b1;
                out_item_nxt   = '0;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                front_nxt = slot_idx;
                count_nxt = count_r - ONE_C;
              end
            end
            OP_POP_BACK: begin
              if (count_r == '0) begin
                out_strobe_nxt = 1'b1;
                out_item_nxt   = '0;
              end else begin
                mem_re    = 1'b1;
                count_nxt = count_r - ONE_C;
              end
            end
            OP_PURGE: begin
              if (count_r == '0) begin
                out_strobe_nxt = 1'b1;
                out_item_nxt   = '0;
              end else begin
                rd_ptr_nxt = front_r;
                wr_ptr_nxt = front_r;
                left_nxt   = count_r;
                kept_nxt   = '0;
                sym_nxt    = in_item.symbol;
              end
            end
            OP_LENGTH: begin
              out_strobe_nxt              = 1'b1;
              out_item_nxt.amount         = to_amount(count_r);
              out_item_nxt.removed_symbol = '0;
              out_item_nxt.symbol_valid   = 1'b0;
            end
            default: begin
              out_strobe_nxt = 1'b0;
            end
          endcase
        end
      end

      // Read data of the pop is back from the ring store.
      ST_POP: begin
        out_strobe_nxt              = 1'b1;
        out_item_nxt.amount         = to_amount(ONE_C);
        out_item_nxt.removed_symbol = rd_data_r;
        out_item_nxt.symbol_valid   = 1'b1;
      end

      // Read one element per cycle and write back the ones that stay.
      ST_PURGE: begin
        if (left_r != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_ptr_r;
          rd_ptr_nxt = wrap_inc(rd_ptr_r);
          left_nxt   = left_r - ONE_C;
          pend_nxt   = 1'b1;
        end
        if (pend_r && rd_data_r != sym_r) begin
          mem_we     = 1'b1;
          mem_waddr  = wr_ptr_r;
          mem_wdata  = rd_data_r;
          wr_ptr_nxt = wrap_inc(wr_ptr_r);
          kept_nxt   = kept_r + ONE_C;
        end
        if (left_r == '0 && !pend_r) begin
          count_nxt      = kept_r;
          out_strobe_nxt = 1'b1;
          if (count_r != kept_r) begin
            out_item_nxt.amount         = to_amount(count_r - kept_r);
            out_item_nxt.removed_symbol = sym_r;
            out_item_nxt.symbol_valid   = 1'b1;
          end else begin
            out_item_nxt = '0;
          end
        end
      end

      default: begin
        out_strobe_nxt = 1'b0;
      end
    endcase
  end

  // Ring store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[mem_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      front_r      <= '0;
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    left_r     <= left_nxt;
    kept_r     <= kept_nxt;
    sym_r      <= sym_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // The element count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("element count above capacity");

  // A pop always delivers its beat in the cycle after the ST_POP state.
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |=> out_strobe)
    else $error("pop finished without a result beat");

  // During a purge, kept plus unread elements never exceed the count.
  a_purge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PURGE) |->
      ((CW + 1)'(kept_r) + (CW + 1)'(left_r) <= (CW + 1)'(count_r)))
    else $error("purge walk overran the stored elements");

  // A push into a full deque leaves the count alone.
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && count_r == CAP_C &&
     (in_op == OP_PUSH_FRONT || in_op == OP_PUSH_BACK)) |=> $stable(count_r))
    else $error("push into full deque changed the count");

  // The sequencer only leaves idle for an accepted beat.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a start");

endmodule

### tb/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker: prediction and comparison for the character deque
// Watches the command and result channels of the deque, keeps its own copy
// of the ring store, front slot and element count, predicts the result beat
// of every accepted command and compares each result beat with the oldest
// prediction still due.
// ----------------------------------------------------------------------------
module cdq_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  cdq_pkg::cdq_in_t  in_item,
  input  logic              out_strobe,
  input  cdq_pkg::cdq_out_t out_item,
  output int                fail_count,
  output int                pending
);
  import cdq_pkg::*;

  localparam int DEPTH = CDQ_CAPACITY;

  // Shadow copy of the deque.
  logic [SYMBOL_W-1:0] ring [DEPTH];
  int                  front_slot;
  int                  occupancy;

  // Result beats still due, oldest first.
  cdq_out_t due_results[$];
  int       mismatch_total = 0;

  // Counts one failure and prints a line for it.
  task automatic report_mismatch(input string what);
    mismatch_total++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Applies one command to the shadow deque and works out its result beat.
  task automatic step_deque(input cdq_in_t beat, output bit yields, output cdq_out_t res);
    int                  kept;
    int                  rd_slot;
    logic [SYMBOL_W-1:0] ch;
    yields = 1'b1;
    res    = '0;
    case (beat.operation)
      OP_PUSH_FRONT: begin
        yields = 1'b0;
        if (occupancy < DEPTH) begin
          front_slot       = (front_slot + DEPTH - 1) % DEPTH;
          ring[front_slot] = beat.symbol;
          occupancy++;
        end
      end
      OP_PUSH_BACK: begin
        yields = 1'b0;
        if (occupancy < DEPTH) begin
          ring[(front_slot + occupancy) % DEPTH] = beat.symbol;
          occupancy++;
        end
      end
      OP_POP_FRONT: begin
        if (occupancy > 0) begin
          res.amount         = 9'd1;
          res.removed_symbol = ring[front_slot];
          res.symbol_valid   = 1'b1;
          front_slot         = (front_slot + 1) % DEPTH;
          occupancy--;
        end
      end
      OP_POP_BACK: begin
        if (occupancy > 0) begin
          res.amount         = 9'd1;
          res.removed_symbol = ring[(front_slot + occupancy - 1) % DEPTH];
          res.symbol_valid   = 1'b1;
          occupancy--;
        end
      end
      OP_PURGE: begin
        // Compact the survivors toward the front, keeping their order.
        kept = 0;
        for (int i = 0; i < occupancy; i++) begin
          rd_slot = (front_slot + i) % DEPTH;
          ch      = ring[rd_slot];
          if (ch != beat.symbol) begin
            ring[(front_slot + kept) % DEPTH] = ch;
            kept++;
          end
        end
        if (kept != occupancy) begin
          res.amount         = AMOUNT_W'(occupancy - kept);
          res.removed_symbol = beat.symbol;
          res.symbol_valid   = 1'b1;
        end
        occupancy = kept;
      end
      OP_LENGTH: begin
        res.amount = AMOUNT_W'(occupancy);
      end
      default: begin
        yields = 1'b0;
      end
    endcase
  endtask

  // Result beats are checked before the command of the same edge is taken in,
  // since a command never yields its result at the edge that accepts it.
  always @(posedge clk) begin : watch
    cdq_out_t want;
    cdq_out_t predicted;
    bit       yields;
    if (!rst_n) begin
      front_slot = 0;
      occupancy  = 0;
      due_results.delete();
    end else begin
      if (out_strobe === 1'b1) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing due: amount %0d symbol %02h valid %0b",
                                    out_item.amount, out_item.removed_symbol,
                                    out_item.symbol_valid));
        end else begin
          want = due_results.pop_front();
          if (out_item.amount !== want.amount) begin
            report_mismatch($sformatf("amount %0d, expected %0d",
                                      out_item.amount, want.amount));
          end
          if (out_item.removed_symbol !== want.removed_symbol) begin
            report_mismatch($sformatf("removed_symbol %02h, expected %02h",
                                      out_item.removed_symbol, want.removed_symbol));
          end
          if (out_item.symbol_valid !== want.symbol_valid) begin
            report_mismatch($sformatf("symbol_valid %0b, expected %0b",
                                      out_item.symbol_valid, want.symbol_valid));
          end
        end
      end
      if (start && !busy) begin
        step_deque(in_item, yields, predicted);
        if (yields) begin
          due_results.push_back(predicted);
        end
      end
    end
    pending    <= due_results.size();
    fail_count <= mismatch_total;
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the character deque with purge
// Drives commands into the deque: a directed opening over the corner cases,
// a fill to capacity and a purge of the whole store, then random segments
// that favor filling, draining, purging or a mix, over narrow or wide alphabets.
// A checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import cdq_pkg::*;

  // Codes the block must ignore.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_OPS = 1520;
  localparam int QUIET_TAIL = 300;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  cdq_in_t  in_item;
  logic     out_strobe;
  cdq_out_t out_item;
  int       fail_count;
  int       pending;

  int ops_issued = 0;
  int random_ops = 0;

  char_deque_with_purge u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  cdq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Issues one command beat and returns at the edge that takes it.
  task automatic issue(input logic [OP_W-1:0] op, input logic [SYMBOL_W-1:0] sym);
    in_item <= '{operation: op, symbol: sym};
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op <= OP_LENGTH) ops_issued++;
  endtask

  // Sender gap with junk on the command bus.
  task automatic idle(input int cycles);
    start   <= 1'b0;
    in_item <= '{operation: OP_W'($urandom), symbol: SYMBOL_W'($urandom)};
    repeat (cycles) @(posedge clk);
  endtask

  // Holds off until every predicted result beat has arrived.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                  seg_len;
    int                  mode;
    int                  roll;
    bit                  narrow;
    bit                  quiet;
    logic [SYMBOL_W-1:0] base;
    logic [SYMBOL_W-1:0] sym;
    logic [OP_W-1:0]     op;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty pops and purge, ignored codes, field extremes.
    issue(OP_POP_FRONT,  8'h00);
    issue(OP_POP_BACK,   8'hFF);
    issue(OP_PURGE,      8'h00);
    issue(OP_LENGTH,     8'hFF);
    issue(OP_SPARE_6,    8'h55);
    issue(OP_SPARE_7,    8'hAA);
    issue(OP_PUSH_BACK,  8'h00);
    issue(OP_PUSH_BACK,  8'hFF);
    idle(2);
    issue(OP_PUSH_FRONT, 8'h80);
    issue(OP_PUSH_FRONT, 8'h01);
    issue(OP_PUSH_BACK,  8'hFF);
    issue(OP_LENGTH,     8'h00);
    issue(OP_PURGE,      8'hFF);
    issue(OP_PURGE,      8'h7E);
    issue(OP_POP_FRONT,  8'h00);
    idle(1);
    issue(OP_POP_BACK,   8'h00);
    issue(OP_POP_BACK,   8'h00);
    issue(OP_POP_FRONT,  8'h00);
    issue(OP_LENGTH,     8'h00);

    // Fill past capacity with one character, then purge the whole store.
    for (int i = 0; i < CDQ_CAPACITY + 2; i++) begin
      if ($urandom_range(0, 99) < 10) idle($urandom_range(1, 5));
      issue(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, 8'hC3);
    end
    issue(OP_LENGTH, 8'h00);
    issue(OP_PURGE,  8'hC3);
    issue(OP_LENGTH, 8'h00);

    // The sender waits here for every outstanding result beat.
    wait_drained();

    // Random segments, most biased toward one kind of traffic.
    while (random_ops < RANDOM_OPS) begin
      seg_len = $urandom_range(20, 120);
      mode    = $urandom_range(0, 3);
      narrow  = $urandom_range(0, 1);
      quiet   = ($urandom_range(0, 3) == 0);
      base    = SYMBOL_W'($urandom);
      for (int k = 0; k < seg_len && random_ops < RANDOM_OPS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
        end else begin
          roll = $urandom_range(0, 99);
          case (mode)
            0:       op = (roll < 85) ? op_t'($urandom_range(0, 1))
                                      : op_t'($urandom_range(2, 5));
            1:       op = (roll < 85) ? op_t'($urandom_range(2, 3))
                                      : op_t'($urandom_range(0, 5));
            2:       op = op_t'($urandom_range(0, 5));
            default: op = (roll < 25) ? OP_PURGE
                                      : ((roll < 80) ? op_t'($urandom_range(0, 1))
                                                     : op_t'($urandom_range(2, 5)));
          endcase
        end
        sym = narrow ? base + SYMBOL_W'($urandom_range(0, 3)) : SYMBOL_W'($urandom);
        if (!quiet && random_ops < RANDOM_OPS - QUIET_TAIL && $urandom_range(0, 99) < 15) begin
          idle($urandom_range(1, 5));
        end
        issue(op, sym);
        if (op <= OP_LENGTH) random_ops++;
      end
    end

    // Let the last results arrive, then allow for a trailing purge walk.
    wait_drained();
    repeat (CDQ_CAPACITY + 40) @(posedge clk);

    $display("covered %0d commands: corner cases, a fill to capacity with a whole-store purge,",
             ops_issued);
    $display("and random fill, drain and purge traffic over narrow and wide alphabets");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #36000000;
    $display("timeout with %0d results still due", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
rtl/cdq_pkg.sv
rtl/char_deque_with_purge.sv
tb/cdq_checker.sv
tb/tb_top.sv
